// File: src/char_class_transliterator_defines.svh
// Assertion macros used by the checker file of the transliterator.
`ifndef CHAR_CLASS_TRANSLITERATOR_DEFINES_SVH
`define CHAR_CLASS_TRANSLITERATOR_DEFINES_SVH

// Same-cycle implication, off while reset is held.
`define CCT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, off while reset is held.
`define CCT_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

// Plain condition checked at every rising clock edge, reset included.
`define CCT_ASSERT_ALWAYS(label, clk, cond, msg) \
	label: assert property (@(posedge clk) (cond)) else $error(msg);

`endif

// File: src/cct_pkg.sv
// Types, codes and constants shared by the transliterator modules.
package cct_pkg;

	localparam int CLASS_DEPTH_DEF = 256;
	localparam int MAP_ENTRIES     = 256;
	localparam int WINDOW_LEN      = 3;
	localparam int IN_DEPTH        = 2;
	localparam int OUT_DEPTH       = 4;
	localparam int OUT_CW          = $clog2(OUT_DEPTH + 1);

	localparam logic [7:0] DASH_BYTE = 8'h2D;

	typedef enum logic [1:0] {
		CMD_CLEAR   = 2'd0,
		CMD_SEARCH  = 2'd1,
		CMD_REPLACE = 2'd2,
		CMD_DATA    = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		OP_CLEAR = 2'd0,
		OP_DESC  = 2'd1,
		OP_DATA  = 2'd2
	} op_kind_t;

	typedef enum logic [2:0] {
		ERR_NONE     = 3'd0,
		ERR_RANGE    = 3'd1,
		ERR_OVERFLOW = 3'd2,
		ERR_EMPTY    = 3'd3,
		ERR_MISMATCH = 3'd4
	} err_t;

	typedef enum logic {
		ST_IDLE   = 1'b0,
		ST_APPEND = 1'b1
	} eng_state_t;

	typedef enum logic {
		SEQ_LIST  = 1'b0,
		SEQ_RANGE = 1'b1
	} seq_mode_t;

	// Classified request handed from front to back.
	typedef struct packed {
		op_kind_t   kind;
		logic       to_search;
		logic [7:0] value;
		logic       last;
	} op_t;

	// Finished result waiting for the receiver.
	typedef struct packed {
		logic [7:0] value;
		err_t       status;
		logic       last;
	} res_t;

endpackage

// File: src/cct_fifo.sv
// Small synchronous first-in first-out queue with occupancy count.
module cct_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  logic [WIDTH-1:0]           din,
	input  logic                       pop,
	output logic [WIDTH-1:0]           dout,
	output logic                       full,
	output logic                       empty,
	output logic [$clog2(DEPTH+1)-1:0] count
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign count   = count_q;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rd_ptr_q];

	// Store the incoming request
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: src/cct_front.sv
// Front end: accepts requests, classifies the command and queues them.
module cct_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	output logic           full,
	input  logic [1:0]     command,
	input  logic [7:0]     byte_value,
	input  logic           last,
	output cct_pkg::op_t   op,
	output logic           op_valid,
	input  logic           op_pop
);

	localparam int OPW = $bits(cct_pkg::op_t);

	cct_pkg::op_t             op_in;
	logic [OPW-1:0]           q_dout;
	logic                     q_empty;
	logic [$clog2(cct_pkg::IN_DEPTH+1)-1:0] q_count;

	// Classify the command into an operation kind and target class
	always_comb begin
		op_in.value     = byte_value;
		op_in.last      = last;
		op_in.to_search = 1'b0;
		op_in.kind      = cct_pkg::OP_DATA;
		case (cct_pkg::cmd_t'(command))
			cct_pkg::CMD_CLEAR: begin
				op_in.kind = cct_pkg::OP_CLEAR;
			end
			cct_pkg::CMD_SEARCH: begin
				op_in.kind      = cct_pkg::OP_DESC;
				op_in.to_search = 1'b1;
			end
			cct_pkg::CMD_REPLACE: begin
				op_in.kind = cct_pkg::OP_DESC;
			end
			cct_pkg::CMD_DATA: begin
				op_in.kind = cct_pkg::OP_DATA;
			end
			default: begin
				op_in.kind = cct_pkg::OP_DATA;
			end
		endcase
	end

	// Decouple the classifier from the back end
	cct_fifo #(
		.WIDTH(OPW),
		.DEPTH(cct_pkg::IN_DEPTH)
	) u_op_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.din   (op_in),
		.pop   (op_pop),
		.dout  (q_dout),
		.full  (full),
		.empty (q_empty),
		.count (q_count)
	);

	assign op       = cct_pkg::op_t'(q_dout);
	assign op_valid = !q_empty && (q_count != '0);

endmodule

// File: src/cct_back.sv
// Back end: class building sequencer, byte map memories and lookup pipeline.
module cct_back #(
	parameter int CLASS_DEPTH = cct_pkg::CLASS_DEPTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  cct_pkg::op_t                op,
	input  logic                        op_valid,
	output logic                        op_pop,
	input  logic [cct_pkg::OUT_CW-1:0]  out_count,
	output cct_pkg::res_t               res,
	output logic                        res_valid
);

	localparam int IW = $clog2(CLASS_DEPTH);
	localparam int CW = $clog2(CLASS_DEPTH + 1);
	localparam int UW = cct_pkg::OUT_CW + 1;

	// Engine state
	cct_pkg::eng_state_t state_q, state_d;
	cct_pkg::seq_mode_t  mode_q, mode_d;
	cct_pkg::err_t       err_q, err_d;
	logic [CW-1:0]       sc_q, sc_d;
	logic [CW-1:0]       rc_q, rc_d;
	logic [1:0]          pc_q, pc_d;
	logic [7:0]          win_q [cct_pkg::WINDOW_LEN];
	logic [7:0]          win_d [cct_pkg::WINDOW_LEN];
	logic [7:0]          list_q [cct_pkg::WINDOW_LEN];
	logic [7:0]          list_d [cct_pkg::WINDOW_LEN];
	logic [1:0]          len_q, len_d;
	logic [1:0]          k_q, k_d;
	logic [7:0]          cur_q, cur_d;
	logic [7:0]          hi_q, hi_d;
	logic                tos_q, tos_d;
	logic [7:0]          echo_q, echo_d;
	logic                last_q, last_d;

	// Window with the new byte placed, and append controls
	logic [7:0]          wn [cct_pkg::WINDOW_LEN];
	logic [7:0]          app_value;
	logic [CW-1:0]       app_cnt;
	logic                app_we;
	logic                map_we;
	logic                clear_all;
	logic                seq_done;
	logic [UW-1:0]       used;
	logic                credit_ok;

	// Result token
	logic                emit;
	logic [7:0]          tok_value;
	logic                tok_last;
	logic                tok_lookup;

	// Map and replace storage
	logic                valid_q [cct_pkg::MAP_ENTRIES];
	logic [IW-1:0]       map_mem [cct_pkg::MAP_ENTRIES];
	logic [7:0]          rep_mem [CLASS_DEPTH];

	// Lookup pipeline
	logic                v_s1, v_s2;
	logic [7:0]          val_s1, val_s2;
	cct_pkg::err_t       status_s1, status_s2;
	logic                last_s1, last_s2;
	logic                look_s1, look_s2;
	logic [IW-1:0]       map_rd_s1;
	logic [7:0]          rep_rd_s2;

	assign used      = UW'(out_count) + UW'(v_s1) + UW'(v_s2);
	assign credit_ok = (used < UW'(cct_pkg::OUT_DEPTH));
	assign app_value = (mode_q == cct_pkg::SEQ_RANGE) ? cur_q : list_q[k_q];
	assign app_cnt   = tos_q ? sc_q : rc_q;
	assign map_we    = app_we && tos_q && !valid_q[app_value];
	assign seq_done  = (mode_q == cct_pkg::SEQ_RANGE) ? (cur_q == hi_q)
	                                                  : (k_q == len_q - 2'd1);

	// Place the incoming byte into the pending window
	always_comb begin
		for (int k = 0; k < cct_pkg::WINDOW_LEN; k++) begin
			wn[k] = (pc_q == 2'(k)) ? op.value : win_q[k];
		end
	end

	// Next state, class updates and result emission
	always_comb begin
		state_d    = state_q;
		mode_d     = mode_q;
		err_d      = err_q;
		sc_d       = sc_q;
		rc_d       = rc_q;
		pc_d       = pc_q;
		win_d      = win_q;
		list_d     = list_q;
		len_d      = len_q;
		k_d        = k_q;
		cur_d      = cur_q;
		hi_d       = hi_q;
		tos_d      = tos_q;
		echo_d     = echo_q;
		last_d     = last_q;
		op_pop     = 1'b0;
		app_we     = 1'b0;
		clear_all  = 1'b0;
		emit       = 1'b0;
		tok_value  = echo_q;
		tok_last   = last_q;
		tok_lookup = 1'b0;
		case (state_q)
			cct_pkg::ST_IDLE: begin
				tok_value = op.value;
				tok_last  = op.last;
				if (op_valid && credit_ok) begin
					op_pop = 1'b1;
					echo_d = op.value;
					last_d = op.last;
					case (op.kind)
						cct_pkg::OP_CLEAR: begin
							sc_d      = '0;
							rc_d      = '0;
							pc_d      = '0;
							err_d     = cct_pkg::ERR_NONE;
							clear_all = 1'b1;
							emit      = 1'b1;
						end
						cct_pkg::OP_DATA: begin
							// Check the classes before the first mapped byte
							if (err_q == cct_pkg::ERR_NONE) begin
								if (sc_q == '0) begin
									err_d = cct_pkg::ERR_EMPTY;
								end else if (sc_q != rc_q) begin
									err_d = cct_pkg::ERR_MISMATCH;
								end
							end
							tok_lookup = (err_d == cct_pkg::ERR_NONE) && valid_q[op.value];
							emit       = 1'b1;
						end
						cct_pkg::OP_DESC: begin
							tos_d = op.to_search;
							if (err_q != cct_pkg::ERR_NONE) begin
								// Drop description bytes while an error is held
								pc_d = '0;
								emit = 1'b1;
							end else if (pc_q == 2'd2) begin
								if (wn[1] == cct_pkg::DASH_BYTE) begin
									pc_d = '0;
									if (wn[0] > wn[2]) begin
										err_d = cct_pkg::ERR_RANGE;
										emit  = 1'b1;
									end else begin
										mode_d  = cct_pkg::SEQ_RANGE;
										cur_d   = wn[0];
										hi_d    = wn[2];
										state_d = cct_pkg::ST_APPEND;
									end
								end else begin
									// Flush the oldest byte, all three on a last flag
									mode_d   = cct_pkg::SEQ_LIST;
									list_d   = wn;
									k_d      = '0;
									len_d    = op.last ? 2'd3 : 2'd1;
									win_d[0] = wn[1];
									win_d[1] = wn[2];
									pc_d     = op.last ? 2'd0 : 2'd2;
									state_d  = cct_pkg::ST_APPEND;
								end
							end else begin
								win_d = wn;
								if (op.last) begin
									mode_d  = cct_pkg::SEQ_LIST;
									list_d  = wn;
									k_d     = '0;
									len_d   = pc_q + 2'd1;
									pc_d    = '0;
									state_d = cct_pkg::ST_APPEND;
								end else begin
									pc_d = pc_q + 2'd1;
									emit = 1'b1;
								end
							end
						end
						default: begin
							emit = 1'b1;
						end
					endcase
				end
			end
			cct_pkg::ST_APPEND: begin
				// One class entry per cycle; stop on overflow
				if (app_cnt == CW'(CLASS_DEPTH)) begin
					err_d   = cct_pkg::ERR_OVERFLOW;
					pc_d    = '0;
					emit    = 1'b1;
					state_d = cct_pkg::ST_IDLE;
				end else begin
					app_we = 1'b1;
					if (tos_q) begin
						sc_d = sc_q + 1'b1;
					end else begin
						rc_d = rc_q + 1'b1;
					end
					if (seq_done) begin
						emit    = 1'b1;
						state_d = cct_pkg::ST_IDLE;
					end else begin
						cur_d = cur_q + 8'd1;
						k_d   = k_q + 2'd1;
					end
				end
			end
			default: begin
				state_d = cct_pkg::ST_IDLE;
			end
		endcase
	end

	// Hold the engine state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cct_pkg::ST_IDLE;
			err_q   <= cct_pkg::ERR_NONE;
			sc_q    <= '0;
			rc_q    <= '0;
			pc_q    <= '0;
		end else begin
			state_q <= state_d;
			err_q   <= err_d;
			sc_q    <= sc_d;
			rc_q    <= rc_d;
			pc_q    <= pc_d;
		end
	end

	// Sequencer payload
	always_ff @(posedge clk) begin
		mode_q <= mode_d;
		win_q  <= win_d;
		list_q <= list_d;
		len_q  <= len_d;
		k_q    <= k_d;
		cur_q  <= cur_d;
		hi_q   <= hi_d;
		tos_q  <= tos_d;
		echo_q <= echo_d;
		last_q <= last_d;
	end

	// Mark byte values that already have a first search position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < cct_pkg::MAP_ENTRIES; i++) begin
				valid_q[i] <= 1'b0;
			end
		end else if (clear_all) begin
			for (int i = 0; i < cct_pkg::MAP_ENTRIES; i++) begin
				valid_q[i] <= 1'b0;
			end
		end else if (map_we) begin
			valid_q[app_value] <= 1'b1;
		end
	end

	// Byte to first search position map
	always_ff @(posedge clk) begin
		if (map_we) begin
			map_mem[app_value] <= sc_q[IW-1:0];
		end
		map_rd_s1 <= map_mem[op.value];
	end

	// Replace class store
	always_ff @(posedge clk) begin
		if (app_we && !tos_q) begin
			rep_mem[rc_q[IW-1:0]] <= app_value;
		end
		rep_rd_s2 <= rep_mem[map_rd_s1];
	end

	// Advance result tokens alongside the memory reads
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= emit;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		val_s1    <= tok_value;
		status_s1 <= err_d;
		last_s1   <= tok_last;
		look_s1   <= tok_lookup;
		val_s2    <= val_s1;
		status_s2 <= status_s1;
		last_s2   <= last_s1;
		look_s2   <= look_s1;
	end

	assign res_valid    = v_s2;
	assign res.value    = look_s2 ? rep_rd_s2 : val_s2;
	assign res.status   = status_s2;
	assign res.last     = last_s2;

endmodule

// File: src/char_class_transliterator.sv
// Top level of the character class transliterator.
//
// Input queue: present command, byte_value and last with push; a request is
// taken at a clock edge with push high and full low. Result queue: while
// empty is low the oldest result sits on result_byte, status and last_out;
// it is taken at an edge with pop high.
// Every request yields exactly one result, in request order. Data bytes are
// mapped through a prebuilt byte map: clear, data and description bytes that
// only enter the pending window are taken back to back while the result
// queue has room. A description byte that flushes entries into a class holds
// the engine while they are written one at a time (up to 3 for a plain
// flush, hi - lo + 1 for a range), through the single write port of the
// class memories; an overflow ends the flush early.
// An accepted request passes the input queue, lookup stages s1 and s2 and
// the result queue before empty goes low. A stalled receiver fills the
// 4-entry result queue; the engine then stops taking requests, the 2-entry
// input queue fills and full rises, with nothing lost.
// Reset empties both queues, zeroes class counts and the error code, and
// clears the byte map valid bits; class memories keep stale contents that
// never reach a result. No clearing pass is needed.
module char_class_transliterator #(
	parameter int CLASS_DEPTH = cct_pkg::CLASS_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [1:0] command,
	input  logic [7:0] byte_value,
	input  logic       last,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] result_byte,
	output logic [2:0] status,
	output logic       last_out
);

	localparam int RW = $bits(cct_pkg::res_t);

	cct_pkg::op_t                 op;
	logic                         op_valid;
	logic                         op_pop;
	cct_pkg::res_t                res;
	logic                         res_valid;
	logic [RW-1:0]                out_dout;
	logic                         out_full;
	logic [cct_pkg::OUT_CW-1:0]   out_count;
	cct_pkg::res_t                out_res;

	cct_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.command   (command),
		.byte_value(byte_value),
		.last      (last),
		.op        (op),
		.op_valid  (op_valid),
		.op_pop    (op_pop)
	);

	cct_back #(
		.CLASS_DEPTH(CLASS_DEPTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.op       (op),
		.op_valid (op_valid),
		.op_pop   (op_pop),
		.out_count(out_count),
		.res      (res),
		.res_valid(res_valid)
	);

	// Hold finished results until the receiver pops them
	cct_fifo #(
		.WIDTH(RW),
		.DEPTH(cct_pkg::OUT_DEPTH)
	) u_res_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (res_valid && !out_full),
		.din   (res),
		.pop   (pop),
		.dout  (out_dout),
		.full  (out_full),
		.empty (empty),
		.count (out_count)
	);

	assign out_res     = cct_pkg::res_t'(out_dout);
	assign result_byte = out_res.value;
	assign status      = out_res.status;
	assign last_out    = out_res.last;

endmodule

// File: src/cct_checker.sv
// Port-level checks for the transliterator and their binding.
`include "char_class_transliterator_defines.svh"

module cct_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       full,
	input logic       empty,
	input logic       pop,
	input logic [7:0] result_byte,
	input logic [2:0] status
);

	logic       prev_err_q;
	logic [2:0] prev_status_q;

	// Track the status of the last popped result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_err_q    <= 1'b0;
			prev_status_q <= cct_pkg::ERR_NONE;
		end else if (!empty && pop) begin
			prev_err_q    <= (status != cct_pkg::ERR_NONE);
			prev_status_q <= status;
		end
	end

	`CCT_ASSERT_IMP(a_status_code, clk, arst_n, !empty, status <= cct_pkg::ERR_MISMATCH, "status code out of range")
	`CCT_ASSERT_NXT(a_stall_hold, clk, arst_n, !empty && !pop, !empty && $stable(result_byte) && $stable(status), "result changed while stalled")
	`CCT_ASSERT_IMP(a_sticky_err, clk, arst_n, !empty && pop && prev_err_q, status == prev_status_q || status == cct_pkg::ERR_NONE, "error code changed without a clear")
	`CCT_ASSERT_ALWAYS(a_reset_idle, clk, arst_n || (empty && !full), "queues not idle in reset")

endmodule

bind char_class_transliterator cct_checker u_cct_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.full       (full),
	.empty      (empty),
	.pop        (pop),
	.result_byte(result_byte),
	.status     (status)
);

// File: sim/tb_char_class_transliterator.sv
// Self-checking testbench for the character class transliterator.
`timescale 1ns / 1ps

module tb_char_class_transliterator;

	localparam int CLASS_DEPTH = cct_pkg::CLASS_DEPTH_DEF;
	localparam int STALL_LIMIT = 3000;
	localparam int DRAIN_CYCLES = 20;
	localparam int RANDOM_REQS = 550;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       push = 1'b0;
	logic       full;
	logic [1:0] command = cct_pkg::CMD_CLEAR;
	logic [7:0] byte_value = 8'h00;
	logic       last = 1'b0;
	logic       empty;
	logic       pop = 1'b0;
	logic [7:0] result_byte;
	logic [2:0] status;
	logic       last_out;

	// predictor state
	logic [7:0]     search_class[CLASS_DEPTH];
	logic [7:0]     replace_class[CLASS_DEPTH];
	int             search_len = 0;
	int             replace_len = 0;
	logic [7:0]     desc_window[cct_pkg::WINDOW_LEN];
	int             window_fill = 0;
	cct_pkg::err_t  held_err = cct_pkg::ERR_NONE;

	cct_pkg::res_t xlat_results_q[$];
	int   mismatches = 0;
	int   useful_reqs = 0;
	int   idle_cycles = 0;
	int   rx_stall = 0;
	bit   steady_tx = 1'b0;
	bit   steady_rx = 1'b0;

	char_class_transliterator i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.command(command),
		.byte_value(byte_value),
		.last(last),
		.empty(empty),
		.pop(pop),
		.result_byte(result_byte),
		.status(status),
		.last_out(last_out)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Append one entry to a class; flag overflow when it is full.
	function automatic bit class_append(bit to_search, logic [7:0] v);
		if (to_search) begin
			if (search_len >= CLASS_DEPTH) begin
				held_err = cct_pkg::ERR_OVERFLOW;
				return 1'b0;
			end
			search_class[search_len] = v;
			search_len++;
		end else begin
			if (replace_len >= CLASS_DEPTH) begin
				held_err = cct_pkg::ERR_OVERFLOW;
				return 1'b0;
			end
			replace_class[replace_len] = v;
			replace_len++;
		end
		return 1'b1;
	endfunction

	// Shift one description byte through the window, expanding x-y ranges.
	function automatic void take_desc_byte(bit to_search, logic [7:0] b, bit lst);
		int lo;
		int hi;
		if (held_err != cct_pkg::ERR_NONE) begin
			window_fill = 0;
			return;
		end
		if (window_fill >= cct_pkg::WINDOW_LEN)
			window_fill = 0;
		desc_window[window_fill] = b;
		window_fill++;
		if (window_fill == cct_pkg::WINDOW_LEN) begin
			if (desc_window[1] == cct_pkg::DASH_BYTE) begin
				lo = desc_window[0];
				hi = desc_window[2];
				window_fill = 0;
				if (lo > hi) begin
					held_err = cct_pkg::ERR_RANGE;
					return;
				end
				for (int v = lo; v <= hi; v++) begin
					if (!class_append(to_search, v[7:0]))
						return;
				end
			end else begin
				if (!class_append(to_search, desc_window[0])) begin
					window_fill = 0;
					return;
				end
				desc_window[0] = desc_window[1];
				desc_window[1] = desc_window[2];
				window_fill = 2;
			end
		end
		if (lst) begin
			for (int k = 0; k < window_fill; k++) begin
				if (!class_append(to_search, desc_window[k]))
					break;
			end
			window_fill = 0;
		end
	endfunction

	// Check the classes, then map a data byte through the first hit.
	function automatic logic [7:0] map_byte(logic [7:0] b);
		if (held_err == cct_pkg::ERR_NONE) begin
			if (search_len == 0)
				held_err = cct_pkg::ERR_EMPTY;
			else if (search_len != replace_len)
				held_err = cct_pkg::ERR_MISMATCH;
		end
		if (held_err != cct_pkg::ERR_NONE)
			return b;
		for (int i = 0; i < search_len; i++) begin
			if (search_class[i] == b)
				return replace_class[i];
		end
		return b;
	endfunction

	function automatic cct_pkg::res_t transliterate(cct_pkg::cmd_t cmd, logic [7:0] b,
		logic lst);
		cct_pkg::res_t r;
		r.value = b;
		case (cmd)
			cct_pkg::CMD_CLEAR: begin
				search_len = 0;
				replace_len = 0;
				window_fill = 0;
				held_err = cct_pkg::ERR_NONE;
			end
			cct_pkg::CMD_SEARCH: take_desc_byte(1'b1, b, lst);
			cct_pkg::CMD_REPLACE: take_desc_byte(1'b0, b, lst);
			default: r.value = map_byte(b);
		endcase
		r.status = held_err;
		r.last = lst;
		return r;
	endfunction

	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (steady_tx || roll < 60)
			return 0;
		if (roll < 94)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Send one request and queue its predicted result once it is taken.
	task automatic send_request(cct_pkg::cmd_t cmd, logic [7:0] b, logic lst);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		command <= cmd;
		byte_value <= b;
		last <= lst;
		@(posedge clk);
		while (full)
			@(posedge clk);
		if (!(held_err != cct_pkg::ERR_NONE &&
			(cmd == cct_pkg::CMD_SEARCH || cmd == cct_pkg::CMD_REPLACE)))
			useful_reqs++;
		xlat_results_q.push_back(transliterate(cmd, b, lst));
	endtask

	// Hold the sender until every queued result has come back.
	task automatic hold_until_drained();
		push <= 1'b0;
		do
			@(posedge clk);
		while (xlat_results_q.size() != 0);
	endtask

	// Describe a class as literals and ranges of the given lengths.
	task automatic send_class(cct_pkg::cmd_t cmd, int lens[$], ref logic [7:0] hits[$]);
		bit         term;
		bit         lst;
		int         lo;
		logic [7:0] v;
		logic [7:0] hi_b;
		term = ($urandom_range(0, 9) != 0);
		foreach (lens[i]) begin
			lst = term && (i == lens.size() - 1);
			if (lens[i] == 1) begin
				do
					v = 8'($urandom_range(0, 255));
				while (v == cct_pkg::DASH_BYTE);
				hits.push_back(v);
				send_request(cmd, v, lst);
			end else begin
				do
					lo = $urandom_range(0, 256 - lens[i]);
				while (lo == cct_pkg::DASH_BYTE || lo + lens[i] - 1 == cct_pkg::DASH_BYTE);
				hi_b = 8'(lo + lens[i] - 1);
				hits.push_back(lo[7:0]);
				hits.push_back(hi_b);
				hits.push_back(8'(lo + lens[i] / 2));
				send_request(cmd, lo[7:0], 1'b0);
				send_request(cmd, cct_pkg::DASH_BYTE, 1'b0);
				send_request(cmd, hi_b, lst);
			end
		end
	endtask

	// Empty search class after a clear, then two data bytes.
	task automatic test_empty_class();
		send_request(cct_pkg::CMD_CLEAR, 8'hFF, 1'b1);
		send_request(cct_pkg::CMD_DATA, 8'h41, 1'b0);
		send_request(cct_pkg::CMD_DATA, 8'h00, 1'b1);
	endtask

	// Range search class against a literal replace class.
	task automatic test_basic_map();
		send_request(cct_pkg::CMD_CLEAR, 8'h00, 1'b0);
		send_request(cct_pkg::CMD_SEARCH, "a", 1'b0);
		send_request(cct_pkg::CMD_SEARCH, cct_pkg::DASH_BYTE, 1'b0);
		send_request(cct_pkg::CMD_SEARCH, "c", 1'b1);
		send_request(cct_pkg::CMD_REPLACE, "x", 1'b0);
		send_request(cct_pkg::CMD_REPLACE, "y", 1'b0);
		send_request(cct_pkg::CMD_REPLACE, "z", 1'b1);
		send_request(cct_pkg::CMD_DATA, "b", 1'b0);
		send_request(cct_pkg::CMD_DATA, "d", 1'b0);
		send_request(cct_pkg::CMD_DATA, 8'hFF, 1'b1);
	endtask

	// Short tail at the last flag is taken verbatim and unbalances the classes.
	task automatic test_short_tail();
		send_request(cct_pkg::CMD_SEARCH, "q", 1'b0);
		send_request(cct_pkg::CMD_SEARCH, cct_pkg::DASH_BYTE, 1'b1);
		send_request(cct_pkg::CMD_DATA, "q", 1'b1);
	endtask

	// Descending range, then a description byte under the held error.
	task automatic test_bad_range();
		send_request(cct_pkg::CMD_CLEAR, 8'h55, 1'b0);
		send_request(cct_pkg::CMD_SEARCH, "z", 1'b0);
		send_request(cct_pkg::CMD_SEARCH, cct_pkg::DASH_BYTE, 1'b0);
		send_request(cct_pkg::CMD_SEARCH, "a", 1'b0);
		send_request(cct_pkg::CMD_SEARCH, "k", 1'b1);
	endtask

	// Full 0..255 range fills the class; one more entry overflows.
	task automatic test_overflow();
		hold_until_drained();
		send_request(cct_pkg::CMD_CLEAR, 8'hAA, 1'b1);
		send_request(cct_pkg::CMD_SEARCH, 8'h00, 1'b0);
		send_request(cct_pkg::CMD_SEARCH, cct_pkg::DASH_BYTE, 1'b0);
		send_request(cct_pkg::CMD_SEARCH, 8'hFF, 1'b0);
		send_request(cct_pkg::CMD_SEARCH, 8'h80, 1'b1);
	endtask

	// Mostly well-formed clear/search/replace/data runs with noise mixed in.
	task automatic test_random_sequences();
		int         goal;
		int         seq_idx;
		int         roll;
		int         n;
		int         lens[$];
		logic [7:0] hits[$];
		logic [7:0] spare[$];
		logic [7:0] b;
		goal = useful_reqs + RANDOM_REQS;
		seq_idx = 0;
		while (useful_reqs < goal) begin
			seq_idx++;
			steady_tx = ($urandom_range(0, 3) == 0);
			steady_rx = ($urandom_range(0, 3) == 0);
			// noise: any command, any byte, any flag
			if ($urandom_range(0, 4) == 0) begin
				n = $urandom_range(1, 4);
				repeat (n)
					send_request(cct_pkg::cmd_t'($urandom_range(0, 3)),
						8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
			end
			if ($urandom_range(0, 9) != 0)
				send_request(cct_pkg::CMD_CLEAR, 8'($urandom_range(0, 255)),
					1'($urandom_range(0, 1)));
			lens.delete();
			hits.delete();
			n = $urandom_range(1, 5);
			repeat (n) begin
				roll = $urandom_range(0, 9);
				if (roll < 5)
					lens.push_back(1);
				else if (roll < 9)
					lens.push_back($urandom_range(2, 8));
				else
					lens.push_back($urandom_range(30, 200));
			end
			send_class(cct_pkg::CMD_SEARCH, lens, hits);
			// occasionally unbalance the replace class
			if ($urandom_range(0, 4) == 0) begin
				if ($urandom_range(0, 1) && lens.size() > 1)
					void'(lens.pop_back());
				else
					lens.push_back($urandom_range(1, 3));
			end
			send_class(cct_pkg::CMD_REPLACE, lens, spare);
			if (seq_idx % 8 == 0)
				hold_until_drained();
			n = $urandom_range(2, 14);
			for (int j = 0; j < n; j++) begin
				if (hits.size() != 0 && $urandom_range(0, 9) < 6)
					b = hits[$urandom_range(0, hits.size() - 1)];
				else
					b = 8'($urandom_range(0, 255));
				send_request(cct_pkg::CMD_DATA, b, j == n - 1);
			end
		end
		steady_tx = 1'b0;
		steady_rx = 1'b0;
	endtask

	initial begin
		arst_n <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_class();
		test_basic_map();
		test_short_tail();
		test_bad_range();
		test_overflow();
		test_random_sequences();
		push <= 1'b0;
		do
			@(posedge clk);
		while (xlat_results_q.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// Drive pop with short and long stalls, or none in steady stretches.
	always @(posedge clk) begin : drive_pop
		int roll;
		roll = $urandom_range(0, 99);
		if (rx_stall > 0) begin
			pop <= 1'b0;
			rx_stall <= rx_stall - 1;
		end else begin
			pop <= 1'b1;
			if (!steady_rx && roll < 20)
				rx_stall <= (roll < 2) ? $urandom_range(15, 50) : $urandom_range(1, 3);
		end
	end

	// Compare each popped result with the oldest prediction.
	always @(posedge clk) begin : check_results
		cct_pkg::res_t want;
		if (arst_n && pop && !empty) begin
			if (xlat_results_q.size() == 0) begin
				$error("result with nothing expected: result_byte %0h status %0d",
					result_byte, status);
				mismatches++;
			end else begin
				want = xlat_results_q.pop_front();
				if (result_byte !== want.value) begin
					$error("result_byte: expected %0h, actual %0h", want.value, result_byte);
					mismatches++;
				end
				if (status !== want.status) begin
					$error("status: expected %0d, actual %0d", want.status, status);
					mismatches++;
				end
				if (last_out !== want.last) begin
					$error("last_out: expected %0b, actual %0b", want.last, last_out);
					mismatches++;
				end
			end
		end
	end

	// End the run when nothing moves on either side for too long.
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

endmodule
